// File: hw/rtl/aacrtp_pkg.sv
// Shared types and constants of the AAC RTP packetizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package aacrtp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ID   = 2'd3;

  localparam logic [15:0] RESET_MAX_PACKET   = 16'd1400;
  localparam logic [6:0]  RESET_PAYLOAD_TYPE = 7'd97;

  localparam logic [12:0] ADTS_BYTES    = 13'd7;
  localparam logic [15:0] ALL_HDR_BYTES = 16'd16;
  localparam logic [7:0]  ADTS_SYNC     = 8'hFF;
  localparam logic [3:0]  ADTS_SYNC_LO  = 4'hF;
  localparam logic [7:0]  RTP_BYTE0     = 8'h80;
  localparam logic [7:0]  AU_HDR_LEN_HI = 8'h00;
  localparam logic [7:0]  AU_HDR_LEN_LO = 8'h10;

  // one payload byte request from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic [12:0] remaining;   // this byte and all later payload bytes of the frame
    logic        min_two;     // packet opened here carries at least two bytes
    logic [31:0] timestamp;
    logic [12:0] au_size;
  } cmd_t;

  // settings the back end reads
  typedef struct packed {
    logic [15:0] max_packet;
    logic [6:0]  payload_type;
    logic [31:0] source_id;
    logic        seq_load;
    logic [15:0] seq_value;
  } back_cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/aac_rtp_packetizer.sv
// Top level of the AAC RTP packetizer (RFC 3640 high bit-rate mode).
// Depends on aacrtp_pkg, aacrtp_front, aacrtp_cmd_queue and aacrtp_back.
//
//   channel   ports                                           handshake
//   input     data_byte, frame_length, frame_timestamp       push / full
//   result    out_byte, packet_end                            pop / empty
//   config    cfg_index, cfg_data                             cfg_write
//
// Frame bytes are taken while full is low; a released held first byte blocks
// input while its partner byte waits to be queued. The back end sends one
// packet byte per cycle while pop keeps the output register free: a new
// packet first sends the 16 bytes of its RTP and AU headers, then payload.
// Reset (rst, synchronous) clears control state and restores the register
// defaults. Either side can stall alone: the request queue decouples them.
`default_nettype none

module aac_rtp_packetizer
  import aacrtp_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 4
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input bytes
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            data_byte,
  input  wire logic [12:0]           frame_length,
  input  wire logic [31:0]           frame_timestamp,
  // packet bytes
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 out_byte,
  output logic                       packet_end,
  // configuration writes
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] max_packet;
  logic [6:0]  payload_type;
  logic [31:0] source_id;

  back_cfg_t bcfg;
  cmd_t      f_cmd, q_cmd;
  logic      f_push, q_full, q_valid, q_pop;

  // registers; a start_sequence write also reloads the back end's counter
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet   <= RESET_MAX_PACKET;
      payload_type <= RESET_PAYLOAD_TYPE;
      source_id    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_PACKET:   max_packet   <= cfg_data[15:0];
        REG_PAYLOAD_TYPE: payload_type <= cfg_data[6:0];
        REG_START_SEQ:    ;
        REG_SOURCE_ID:    source_id    <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign bcfg = '{max_packet: max_packet, payload_type: payload_type,
                  source_id: source_id,
                  seq_load: cfg_write && (cfg_index == REG_START_SEQ),
                  seq_value: cfg_data[15:0]};

  // front: ADTS detection, held first byte, payload byte requests
  aacrtp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .frame_length    (frame_length),
    .frame_timestamp (frame_timestamp),
    .cmd_push        (f_push),
    .cmd_out         (f_cmd),
    .cmd_full        (q_full)
  );

  aacrtp_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_push),
    .wr_data  (f_cmd),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  // back: packet opening, header serializer, output register
  aacrtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (bcfg),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .packet_end (packet_end)
  );

endmodule

`default_nettype wire

// File: hw/rtl/aacrtp_front.sv
// Front end: takes frame bytes, strips ADTS headers, issues payload byte requests.
// Depends on aacrtp_pkg.
`default_nettype none

module aacrtp_front
  import aacrtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic [12:0] frame_length,
  input  wire logic [31:0] frame_timestamp,
  output logic             cmd_push,
  output cmd_t             cmd_out,
  input  wire logic        cmd_full
);

  logic [12:0] pos, pos_next;
  logic [12:0] len, len_next;
  logic [7:0]  held, held_next;
  logic        adts, adts_next;
  logic [12:0] aus, aus_next;
  logic [31:0] ts, ts_next;
  logic        pend_v, pend_v_next;
  cmd_t        pend, pend_next;

  logic        accept;
  logic        new_v;
  cmd_t        new_cmd;
  logic [13:0] pos_inc;

  assign full    = pend_v || cmd_full;
  assign accept  = push && !full;
  assign pos_inc = {1'b0, pos} + 14'd1;

  always_comb begin
    pos_next    = pos;
    len_next    = len;
    held_next   = held;
    adts_next   = adts;
    aus_next    = aus;
    ts_next     = ts;
    // a waiting second byte stays until the queue takes it
    pend_v_next = pend_v && cmd_full;
    pend_next   = pend;
    new_v       = 1'b0;
    new_cmd     = '{data: data_byte, remaining: len - pos, min_two: 1'b0,
                    timestamp: ts, au_size: aus};
    if (accept) begin
      if (pos == '0) begin
        if (frame_length != '0) begin
          len_next  = frame_length;
          ts_next   = frame_timestamp;
          adts_next = 1'b0;
          aus_next  = frame_length;
          if (frame_length > ADTS_BYTES) begin
            held_next = data_byte;
            pos_next  = 13'd1;
          end else begin
            new_v   = 1'b1;
            new_cmd = '{data: data_byte, remaining: frame_length, min_two: 1'b0,
                        timestamp: frame_timestamp, au_size: frame_length};
            pos_next = (frame_length == 13'd1) ? '0 : 13'd1;
          end
        end
      end else if (pos == 13'd1 && len > ADTS_BYTES) begin
        if (held == ADTS_SYNC && data_byte[7:4] == ADTS_SYNC_LO) begin
          adts_next = 1'b1;
          aus_next  = len - ADTS_BYTES;
        end else begin
          // release held byte now; second byte waits in pend until the queue takes it
          new_v       = 1'b1;
          new_cmd     = '{data: held, remaining: len, min_two: 1'b1,
                          timestamp: ts, au_size: aus};
          pend_v_next = 1'b1;
          pend_next   = '{data: data_byte, remaining: len - 13'd1, min_two: 1'b0,
                          timestamp: ts, au_size: aus};
        end
        pos_next = 13'd2;
      end else begin
        new_v    = !(adts && pos < ADTS_BYTES);
        pos_next = (pos_inc >= {1'b0, len}) ? '0 : pos_inc[12:0];
      end
    end
  end

  assign cmd_push = pend_v || new_v;
  assign cmd_out  = pend_v ? pend : new_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      len    <= '0;
      held   <= '0;
      adts   <= 1'b0;
      aus    <= '0;
      ts     <= '0;
      pend_v <= 1'b0;
    end else begin
      pos    <= pos_next;
      len    <= len_next;
      held   <= held_next;
      adts   <= adts_next;
      aus    <= aus_next;
      ts     <= ts_next;
      pend_v <= pend_v_next;
    end
    pend <= pend_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/aacrtp_cmd_queue.sv
// Short request queue between front and back end.
// Depends on aacrtp_pkg for the request type.
`default_nettype none

module aacrtp_cmd_queue
  import aacrtp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  cmd_t      wr_data,
  output logic      q_full,
  input  wire logic rd_en,
  output logic      rd_valid,
  output cmd_t      rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign q_full   = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/aacrtp_back.sv
// Back end: opens packets, serializes RTP and AU headers, sends payload bytes.
// Depends on aacrtp_pkg.
`default_nettype none

module aacrtp_back
  import aacrtp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  back_cfg_t  cfg,
  input  wire logic  cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       empty,
  input  wire logic  pop,
  output logic [7:0] out_byte,
  output logic       packet_end
);

  typedef enum logic {ST_RUN, ST_HDR} state_t;

  state_t      state;
  logic [3:0]  idx;
  logic [12:0] left;
  logic        marker;
  logic [15:0] seq;
  logic        out_v;

  logic        adv;
  logic [15:0] chunk, chunk_min;
  logic [12:0] n;
  logic        mk;
  logic [7:0]  hdr_byte;

  assign adv     = !out_v || pop;
  assign empty   = !out_v;
  assign cmd_pop = (state == ST_RUN) && adv && cmd_valid && (left != '0);

  // packet size for a packet opened at the queue head
  always_comb begin
    chunk     = (cfg.max_packet > ALL_HDR_BYTES) ? cfg.max_packet - ALL_HDR_BYTES : '0;
    chunk_min = cmd.min_two ? 16'd2 : 16'd1;
    if (chunk < chunk_min) begin
      chunk = chunk_min;
    end
    mk = ({3'b000, cmd.remaining} <= chunk);
    n  = mk ? cmd.remaining : chunk[12:0];
  end

  always_comb begin
    unique case (idx)
      4'd0:    hdr_byte = RTP_BYTE0;
      4'd1:    hdr_byte = {marker, cfg.payload_type};
      4'd2:    hdr_byte = seq[15:8];
      4'd3:    hdr_byte = seq[7:0];
      4'd4:    hdr_byte = cmd.timestamp[31:24];
      4'd5:    hdr_byte = cmd.timestamp[23:16];
      4'd6:    hdr_byte = cmd.timestamp[15:8];
      4'd7:    hdr_byte = cmd.timestamp[7:0];
      4'd8:    hdr_byte = cfg.source_id[31:24];
      4'd9:    hdr_byte = cfg.source_id[23:16];
      4'd10:   hdr_byte = cfg.source_id[15:8];
      4'd11:   hdr_byte = cfg.source_id[7:0];
      4'd12:   hdr_byte = AU_HDR_LEN_HI;
      4'd13:   hdr_byte = AU_HDR_LEN_LO;
      4'd14:   hdr_byte = cmd.au_size[12:5];
      default: hdr_byte = {cmd.au_size[4:0], 3'b000};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      idx    <= '0;
      left   <= '0;
      marker <= 1'b0;
      seq    <= '0;
      out_v  <= 1'b0;
    end else begin
      if (pop && out_v) begin
        out_v <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (adv && cmd_valid) begin
            out_v <= 1'b1;
            if (left == '0) begin
              out_byte   <= RTP_BYTE0;
              packet_end <= 1'b0;
              left       <= n;
              marker     <= mk;
              idx        <= 4'd1;
              state      <= ST_HDR;
            end else begin
              out_byte   <= cmd.data;
              packet_end <= (left == 13'd1);
              left       <= left - 13'd1;
            end
          end
        end
        ST_HDR: begin
          if (adv) begin
            out_v      <= 1'b1;
            out_byte   <= hdr_byte;
            packet_end <= 1'b0;
            idx        <= idx + 4'd1;
            if (idx == 4'd3) begin
              seq <= seq + 16'd1;
            end
            if (idx == 4'd15) begin
              state <= ST_RUN;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
      if (cfg.seq_load) begin
        seq <= cfg.seq_value;
      end
    end
  end

endmodule

`default_nettype wire
